// ----- rtl/qie_pkg.sv -----
// Types, opcodes and the pixel hash function shared by the QOI encoder blocks.
package qie_pkg;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pixel_t;

  localparam int unsigned INDEX_W     = 6;
  localparam int unsigned INDEX_DEPTH = 64;
  localparam int unsigned CMD_BYTES   = 6;
  localparam int unsigned CMD_CNT_W   = 3;
  localparam int unsigned POS_W       = 4;

  localparam pixel_t PX_RESET = '{r: 8'h00, g: 8'h00, b: 8'h00, a: 8'hFF};

  localparam logic [7:0] OP_DIFF  = 8'h40;
  localparam logic [7:0] OP_LUMA  = 8'h80;
  localparam logic [7:0] OP_RUN   = 8'hC0;
  localparam logic [7:0] OP_RGB   = 8'hFE;
  localparam logic [7:0] OP_RGBA  = 8'hFF;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  localparam logic [7:0] END_BYTE_TAIL = 8'h01;
  localparam logic [7:0] END_BYTE_PAD  = 8'h00;
  localparam logic [POS_W-1:0] END_LEN = 4'd8;

  localparam logic [INDEX_W-1:0] MAX_RUN = 6'd62;

  localparam logic signed [7:0] DIFF_LO = -8'sd2;
  localparam logic signed [7:0] DIFF_HI = 8'sd1;
  localparam logic signed [7:0] LUMA_G_LO = -8'sd32;
  localparam logic signed [7:0] LUMA_G_HI = 8'sd31;
  localparam logic signed [7:0] LUMA_RB_LO = -8'sd8;
  localparam logic signed [7:0] LUMA_RB_HI = 8'sd7;
  localparam logic [7:0] DIFF_BIAS = 8'd2;
  localparam logic [7:0] LUMA_G_BIAS = 8'd32;
  localparam logic [7:0] LUMA_RB_BIAS = 8'd8;

  localparam logic [INDEX_W-1:0] HASH_R = 6'd3;
  localparam logic [INDEX_W-1:0] HASH_G = 6'd5;
  localparam logic [INDEX_W-1:0] HASH_B = 6'd7;
  localparam logic [INDEX_W-1:0] HASH_A = 6'd11;

  // Bytes of one pixel's chunks; data[0] goes out first.
  typedef struct packed {
    logic [CMD_BYTES-1:0][7:0] data;
    logic [CMD_CNT_W-1:0]      nbytes;
    logic                      eoi;
  } cmd_t;

  function automatic logic [INDEX_W-1:0] px_hash(pixel_t p);
    logic [INDEX_W-1:0] hr, hg, hb, ha;
    hr = INDEX_W'(p.r) * HASH_R;
    hg = INDEX_W'(p.g) * HASH_G;
    hb = INDEX_W'(p.b) * HASH_B;
    ha = INDEX_W'(p.a) * HASH_A;
    return hr + hg + hb + ha;
  endfunction

endpackage

// ----- rtl/qie_intf.sv -----
// Handshake channel interfaces: pixel input, byte output, configuration write.
interface qie_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       end_of_image;

  modport source (output valid, red, green, blue, alpha, end_of_image, input ready);
  modport sink   (input valid, red, green, blue, alpha, end_of_image, output ready);
endinterface

interface qie_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

interface qie_cfg_if;
  logic valid;
  logic ready;
  logic has_alpha;

  modport source (output valid, has_alpha, input ready);
  modport sink   (input valid, has_alpha, output ready);
endinterface

// ----- rtl/qoi_image_encoder.sv -----
// QOI chunk encoder top level: pixels in, encoded stream bytes out.
//
// in_pix takes one RGBA pixel per transfer; end_of_image marks the image's
// final pixel. out_strm gives one stream byte per transfer; last is set on
// the final byte caused by a pixel. cfg_wr writes has_alpha (0 forces alpha
// to 255); it is taken in the cycle it is offered.
// A pixel is accepted every cycle while the command queue has room. A pixel's
// first byte is offered after the stage register and the queue. The output
// side moves one byte per cycle while out_strm is ready; a pixel makes 0 or
// 1 bytes on a run, 1 to 6 for a chunk, plus 8 for the end marker. The queue
// of QUEUE_DEPTH commands absorbs multi-byte chunks. When out_strm stalls,
// the queue fills and then in_pix.ready drops; nothing is lost. Reset clears
// the previous pixel to 0,0,0,255, the run count and the color index (valid
// flags), and sets has_alpha to 1. An end-of-image pixel clears the same
// state except has_alpha once its chunks are queued.
module qoi_image_encoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  qie_pix_if.sink    in_pix,
  qie_cfg_if.sink    cfg_wr,
  qie_byte_if.source out_strm
);
  import qie_pkg::*;

  cmd_t front_cmd;
  logic front_valid, front_ready;
  cmd_t back_cmd;
  logic back_valid, back_ready;

  qie_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_pix),
    .cfg_wr    (cfg_wr),
    .cmd_data  (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready)
  );

  qie_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (front_cmd),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_data   (back_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  qie_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_data  (back_cmd),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .out_strm  (out_strm)
  );

endmodule

// ----- rtl/qie_front.sv -----
// Front end: pixel accept, color index lookup, chunk selection, encoder state.
module qie_front (
  input  logic          clk,
  input  logic          rst_n,
  qie_pix_if.sink       in_pix,
  qie_cfg_if.sink       cfg_wr,
  output qie_pkg::cmd_t cmd_data,
  output logic          cmd_valid,
  input  logic          cmd_ready
);
  import qie_pkg::*;

  logic                   has_alpha_r;
  logic                   s1_valid_r;
  pixel_t                 s1_px_r;
  pixel_t                 s1_mem_r;
  logic [INDEX_W-1:0]     s1_h_r;
  logic                   s1_eoi_r;
  pixel_t                 prev_r;
  logic [INDEX_W-1:0]     run_r;
  logic [INDEX_W-1:0]     last_h_r;
  logic                   last_ok_r;
  logic [INDEX_DEPTH-1:0] valid_r;
  pixel_t                 mem [INDEX_DEPTH];

  pixel_t             in_px;
  logic [INDEX_W-1:0] in_h;
  logic               accept;
  logic               s1_fire;
  logic               need_push;
  pixel_t             entry;
  logic               is_run;
  logic [INDEX_W-1:0] run_cnt;
  logic               run_flag;
  logic [INDEX_W-1:0] run_code;
  logic [INDEX_W-1:0] run_nxt;
  logic [7:0]         run_byte;
  logic [7:0]         dr, dg, db, drg, dbg;
  logic [7:0]         dr_b, dg_b, db_b, dg_l, drg_l, dbg_l;
  logic [CMD_BYTES-1:0][7:0] op_bytes;
  logic [CMD_CNT_W-1:0]      op_n;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_alpha_r <= 1'b1;
    end else if (cfg_wr.valid) begin
      has_alpha_r <= cfg_wr.has_alpha;
    end
  end

  assign in_px.r = in_pix.red;
  assign in_px.g = in_pix.green;
  assign in_px.b = in_pix.blue;
  assign in_px.a = has_alpha_r ? in_pix.alpha : ALPHA_OPAQUE;
  assign in_h    = px_hash(in_px);

  assign in_pix.ready = !s1_valid_r || s1_fire;
  assign accept       = in_pix.valid && in_pix.ready;
  assign s1_fire      = s1_valid_r && (!need_push || cmd_ready);
  assign cmd_valid    = s1_valid_r && need_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r  <= in_px;
      s1_h_r   <= in_h;
      s1_eoi_r <= in_pix.end_of_image;
      s1_mem_r <= mem[in_h];
    end
    if (s1_fire) begin
      mem[s1_h_r] <= s1_px_r;
    end
  end

  // read data predates the last write; bypass from the previous pixel
  always_comb begin
    if (last_ok_r && last_h_r == s1_h_r) begin
      entry = prev_r;
    end else if (valid_r[s1_h_r]) begin
      entry = s1_mem_r;
    end else begin
      entry = '0;
    end
  end

  assign is_run  = s1_px_r == prev_r;
  assign run_cnt = run_r + 6'd1;

  always_comb begin
    if (is_run) begin
      run_flag = (run_cnt == MAX_RUN) || s1_eoi_r;
      run_code = run_r;
      run_nxt  = (run_cnt == MAX_RUN) ? '0 : run_cnt;
    end else begin
      run_flag = run_r != '0;
      run_code = run_r - 6'd1;
      run_nxt  = '0;
    end
  end
  assign run_byte = OP_RUN | {2'b00, run_code};

  assign dr  = s1_px_r.r - prev_r.r;
  assign dg  = s1_px_r.g - prev_r.g;
  assign db  = s1_px_r.b - prev_r.b;
  assign drg = dr - dg;
  assign dbg = db - dg;
  assign dr_b  = dr + DIFF_BIAS;
  assign dg_b  = dg + DIFF_BIAS;
  assign db_b  = db + DIFF_BIAS;
  assign dg_l  = dg + LUMA_G_BIAS;
  assign drg_l = drg + LUMA_RB_BIAS;
  assign dbg_l = dbg + LUMA_RB_BIAS;

  always_comb begin
    op_bytes = '0;
    op_n     = '0;
    if (!is_run) begin
      if (entry == s1_px_r) begin
        op_bytes[0] = {2'b00, s1_h_r};
        op_n        = 3'd1;
      end else if (s1_px_r.a == prev_r.a) begin
        if ($signed(dr) >= DIFF_LO && $signed(dr) <= DIFF_HI &&
            $signed(dg) >= DIFF_LO && $signed(dg) <= DIFF_HI &&
            $signed(db) >= DIFF_LO && $signed(db) <= DIFF_HI) begin
          op_bytes[0] = OP_DIFF | {2'b00, dr_b[1:0], dg_b[1:0], db_b[1:0]};
          op_n        = 3'd1;
        end else if ($signed(dg) >= LUMA_G_LO && $signed(dg) <= LUMA_G_HI &&
                     $signed(drg) >= LUMA_RB_LO && $signed(drg) <= LUMA_RB_HI &&
                     $signed(dbg) >= LUMA_RB_LO && $signed(dbg) <= LUMA_RB_HI) begin
          op_bytes[0] = OP_LUMA | {2'b00, dg_l[5:0]};
          op_bytes[1] = {drg_l[3:0], dbg_l[3:0]};
          op_n        = 3'd2;
        end else begin
          op_bytes[0] = OP_RGB;
          op_bytes[1] = s1_px_r.r;
          op_bytes[2] = s1_px_r.g;
          op_bytes[3] = s1_px_r.b;
          op_n        = 3'd4;
        end
      end else begin
        op_bytes[0] = OP_RGBA;
        op_bytes[1] = s1_px_r.r;
        op_bytes[2] = s1_px_r.g;
        op_bytes[3] = s1_px_r.b;
        op_bytes[4] = s1_px_r.a;
        op_n        = 3'd5;
      end
    end
  end

  always_comb begin
    cmd_data.data[0] = run_flag ? run_byte : op_bytes[0];
    for (int i = 1; i < CMD_BYTES; i++) begin
      cmd_data.data[i] = run_flag ? op_bytes[i-1] : op_bytes[i];
    end
    cmd_data.nbytes = op_n + {2'b00, run_flag};
    cmd_data.eoi    = s1_eoi_r;
  end

  assign need_push = run_flag || (op_n != '0) || s1_eoi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= PX_RESET;
      run_r     <= '0;
      valid_r   <= '0;
      last_ok_r <= 1'b0;
      last_h_r  <= '0;
    end else if (s1_fire) begin
      last_h_r <= s1_h_r;
      if (s1_eoi_r) begin
        prev_r    <= PX_RESET;
        run_r     <= '0;
        valid_r   <= '0;
        last_ok_r <= 1'b0;
      end else begin
        prev_r          <= s1_px_r;
        run_r           <= run_nxt;
        valid_r[s1_h_r] <= 1'b1;
        last_ok_r       <= 1'b1;
      end
    end
  end

  a_run_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    run_r < MAX_RUN)
    else $error("run count reached flush limit");

  a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_eoi_r |=> prev_r == PX_RESET && run_r == '0 && valid_r == '0)
    else $error("end of image did not clear state");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> s1_valid_r && $stable(s1_px_r) && $stable(s1_h_r))
    else $error("stalled pixel lost");

endmodule

// ----- rtl/qie_fifo.sv -----
// Command queue between the classifier and the byte serializer.
module qie_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  qie_pkg::cmd_t push_data,
  input  logic          push_valid,
  output logic          push_ready,
  output qie_pkg::cmd_t pop_data,
  output logic          pop_valid,
  input  logic          pop_ready
);
  import qie_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          q_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          push, pop;

  assign push_ready = count_r != CW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

// ----- rtl/qie_back.sv -----
// Back end: serializes queued chunk bytes and the end marker, one per transfer.
module qie_back (
  input  logic          clk,
  input  logic          rst_n,
  input  qie_pkg::cmd_t cmd_data,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  qie_byte_if.source    out_strm
);
  import qie_pkg::*;

  cmd_t             cur_r;
  logic             cur_valid_r;
  logic [POS_W-1:0] pos_r;

  logic [POS_W-1:0] total;
  logic             at_last;
  logic             xfer;

  assign total   = {1'b0, cur_r.nbytes} + (cur_r.eoi ? END_LEN : '0);
  assign at_last = pos_r == total - 1'b1;
  assign xfer    = out_strm.valid && out_strm.ready;

  assign out_strm.valid = cur_valid_r;
  assign out_strm.last  = at_last;

  always_comb begin
    if (pos_r < {1'b0, cur_r.nbytes}) begin
      out_strm.out_byte = cur_r.data[pos_r[CMD_CNT_W-1:0]];
    end else if (at_last) begin
      out_strm.out_byte = END_BYTE_TAIL;
    end else begin
      out_strm.out_byte = END_BYTE_PAD;
    end
  end

  assign cmd_ready = !cur_valid_r || (xfer && at_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      pos_r       <= '0;
    end else if (cmd_ready) begin
      cur_valid_r <= cmd_valid;
      pos_r       <= '0;
    end else if (xfer) begin
      pos_r <= pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      cur_r <= cmd_data;
    end
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> pos_r < total && total != '0)
    else $error("serializer position past end of chunk");

endmodule

// ----- tb/qoi_image_encoder_test.sv -----
`timescale 1ns / 100ps
// Self-checking QOI encoder testbench: directed and random pixel streams, byte-exact prediction.
module qoi_image_encoder_test;
  import qie_pkg::*;

  localparam int          CLK_HALF      = 2;
  localparam int          RESET_CYCLES  = 7;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          CYCLE_LIMIT   = 600000;
  localparam int          RANDOM_PHASES = 5;
  localparam int          PHASE_ITEMS   = 94;
  localparam int          MAX_REPORTS   = 60;
  localparam logic [7:0]  OP_INDEX      = 8'h00;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } strm_byte_t;

  // Predicts the chunk bytes of each accepted pixel and holds them until they come out.
  class qoi_byte_tracker;
    pixel_t     prev_px;
    int         run_len;
    pixel_t     seen_px [INDEX_DEPTH];
    logic       alpha_en;
    logic [7:0] chunk [$];
    strm_byte_t pending_bytes [$];
    int         errors;

    function new();
      alpha_en = 1'b1;
      errors   = 0;
      clear_image();
    endfunction

    function void clear_image();
      prev_px = PX_RESET;
      run_len = 0;
      foreach (seen_px[i]) seen_px[i] = '0;
    endfunction

    function void set_alpha(logic en);
      alpha_en = en;
    endfunction

    function void flush_run();
      if (run_len > 0) begin
        chunk.push_back(OP_RUN | 8'(run_len - 1));
        run_len = 0;
      end
    endfunction

    function void take_pixel(pixel_t raw, logic eoi);
      pixel_t            px;
      logic [5:0]        slot;
      logic signed [7:0] dr, dg, db, drg, dbg;
      logic [7:0]        d0, d1, d2;
      px = raw;
      if (!alpha_en) px.a = ALPHA_OPAQUE;
      slot = 6'((int'(px.r) * HASH_R + int'(px.g) * HASH_G + int'(px.b) * HASH_B +
                 int'(px.a) * HASH_A) % INDEX_DEPTH);
      chunk.delete();
      if (px == prev_px) begin
        run_len++;
        if (run_len >= MAX_RUN) flush_run();
      end else begin
        flush_run();
        dr  = px.r - prev_px.r;
        dg  = px.g - prev_px.g;
        db  = px.b - prev_px.b;
        drg = dr - dg;
        dbg = db - dg;
        if (seen_px[slot] == px) begin
          chunk.push_back(OP_INDEX | {2'b00, slot});
        end else if (px.a == prev_px.a) begin
          if (dr >= DIFF_LO && dr <= DIFF_HI && dg >= DIFF_LO && dg <= DIFF_HI &&
              db >= DIFF_LO && db <= DIFF_HI) begin
            d0 = 8'(dr + DIFF_BIAS);
            d1 = 8'(dg + DIFF_BIAS);
            d2 = 8'(db + DIFF_BIAS);
            chunk.push_back(OP_DIFF | {2'b00, d0[1:0], d1[1:0], d2[1:0]});
          end else if (dg >= LUMA_G_LO && dg <= LUMA_G_HI && drg >= LUMA_RB_LO &&
                       drg <= LUMA_RB_HI && dbg >= LUMA_RB_LO && dbg <= LUMA_RB_HI) begin
            chunk.push_back(OP_LUMA | 8'(dg + LUMA_G_BIAS));
            chunk.push_back({4'(drg + LUMA_RB_BIAS), 4'(dbg + LUMA_RB_BIAS)});
          end else begin
            chunk.push_back(OP_RGB);
            chunk.push_back(px.r);
            chunk.push_back(px.g);
            chunk.push_back(px.b);
          end
        end else begin
          chunk.push_back(OP_RGBA);
          chunk.push_back(px.r);
          chunk.push_back(px.g);
          chunk.push_back(px.b);
          chunk.push_back(px.a);
        end
      end
      seen_px[slot] = px;
      prev_px = px;
      if (eoi) begin
        flush_run();
        repeat (END_LEN - 1) chunk.push_back(END_BYTE_PAD);
        chunk.push_back(END_BYTE_TAIL);
        clear_image();
      end
      foreach (chunk[i]) pending_bytes.push_back('{data: chunk[i], last: i == chunk.size() - 1});
    endfunction

    function void match_byte(logic [7:0] data, logic last);
      strm_byte_t want;
      if (pending_bytes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected byte, expected none, actual %02h last %0b", $time, data, last);
        return;
      end
      want = pending_bytes.pop_front();
      if (data !== want.data) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: out_byte mismatch, expected %02h, actual %02h", $time, want.data, data);
      end
      if (last !== want.last) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: last mismatch, expected %0b, actual %0b", $time, want.last, last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  qie_pix_if  in_pix ();
  qie_byte_if out_strm ();
  qie_cfg_if  cfg_wr ();

  qoi_image_encoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (in_pix),
    .cfg_wr   (cfg_wr),
    .out_strm (out_strm)
  );

  qoi_byte_tracker tracker = new();

  int     tx_gap_max  = 0;
  int     rx_gap_max  = 0;
  int     rx_hold_req = 0;
  int     cycle_count = 0;
  pixel_t last_sent   = PX_RESET;
  pixel_t palette [16];
  int     pal_wr      = 0;

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr.valid && cfg_wr.ready) tracker.set_alpha(cfg_wr.has_alpha);
      if (in_pix.valid && in_pix.ready)
        tracker.take_pixel(pixel_t'({in_pix.red, in_pix.green, in_pix.blue, in_pix.alpha}),
                           in_pix.end_of_image);
      if (out_strm.valid && out_strm.ready) tracker.match_byte(out_strm.out_byte, out_strm.last);
    end
  end

  // Byte sink: random gaps per transfer, plus one long hold-off on request.
  initial begin
    int gap;
    out_strm.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = $urandom_range(rx_gap_max, 0);
      if (rx_hold_req > 0) begin
        gap = rx_hold_req;
        rx_hold_req = 0;
      end
      if (gap > 0) begin
        out_strm.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_strm.ready <= 1'b1;
      do @(posedge clk); while (!(out_strm.valid && out_strm.ready));
    end
  end

  function automatic pixel_t px_of(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    return pixel_t'({r, g, b, a});
  endfunction

  function automatic logic one_in(int n);
    return $urandom_range(n - 1, 0) == 0;
  endfunction

  task automatic send_pixel(pixel_t px, logic eoi);
    int gap;
    gap = $urandom_range(tx_gap_max, 0);
    if (gap > 0) begin
      in_pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_pix.red          <= px.r;
    in_pix.green        <= px.g;
    in_pix.blue         <= px.b;
    in_pix.alpha        <= px.a;
    in_pix.end_of_image <= eoi;
    in_pix.valid        <= 1'b1;
    do @(posedge clk); while (!(in_pix.valid && in_pix.ready));
    palette[pal_wr] = px;
    pal_wr = (pal_wr + 1) % 16;
    last_sent = eoi ? PX_RESET : px;
  endtask

  task automatic wait_drained();
    in_pix.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_alpha(logic en);
    cfg_wr.has_alpha <= en;
    cfg_wr.valid     <= 1'b1;
    do @(posedge clk); while (!(cfg_wr.valid && cfg_wr.ready));
    cfg_wr.valid <= 1'b0;
  endtask

  function automatic pixel_t next_pixel();
    pixel_t px;
    int     pick, dg, drg, dbg;
    px   = last_sent;
    pick = $urandom_range(99, 0);
    if (pick < 30) begin
      px.r = px.r + 8'($urandom_range(3, 0)) - 8'd2;
      px.g = px.g + 8'($urandom_range(3, 0)) - 8'd2;
      px.b = px.b + 8'($urandom_range(3, 0)) - 8'd2;
    end else if (pick < 55) begin
      dg   = $urandom_range(63, 0) - 32;
      drg  = $urandom_range(15, 0) - 8;
      dbg  = $urandom_range(15, 0) - 8;
      px.g = px.g + 8'(dg);
      px.r = px.r + 8'(dg + drg);
      px.b = px.b + 8'(dg + dbg);
    end else if (pick < 72) begin
      px = palette[$urandom_range(15, 0)];
    end else if (pick < 87) begin
      px.r = 8'($urandom);
      px.g = 8'($urandom);
      px.b = 8'($urandom);
    end else if (pick < 97) begin
      px = pixel_t'($urandom);
    end else begin
      px.a = 8'($urandom);
    end
    return px;
  endfunction

  initial begin
    int sent, reps;
    rst_n               <= 1'b0;
    in_pix.valid        <= 1'b0;
    in_pix.red          <= '0;
    in_pix.green        <= '0;
    in_pix.blue         <= '0;
    in_pix.alpha        <= '0;
    in_pix.end_of_image <= 1'b0;
    cfg_wr.valid        <= 1'b0;
    cfg_wr.has_alpha    <= 1'b1;
    foreach (palette[i]) palette[i] = PX_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every chunk type, range edges, runs into end of image
    tx_gap_max = 4;
    rx_gap_max = 4;
    write_alpha(1'b1);
    send_pixel(px_of(8'd0, 8'd0, 8'd0, 8'd0), 1'b0);       // zero pixel hits cleared slot
    send_pixel(px_of(8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
    send_pixel(px_of(8'd1, 8'd0, 8'd255, 8'd0), 1'b0);
    send_pixel(px_of(8'd255, 8'd254, 8'd0, 8'd0), 1'b0);    // diff low edge, wrapped
    send_pixel(px_of(8'd37, 8'd29, 8'd23, 8'd0), 1'b0);     // luma high edge
    send_pixel(px_of(8'd253, 8'd253, 8'd254, 8'd0), 1'b0);  // luma low edge
    send_pixel(px_of(8'd255, 8'd255, 8'd0, 8'd0), 1'b0);
    send_pixel(px_of(8'd10, 8'd200, 8'd90, 8'd0), 1'b0);
    send_pixel(px_of(8'd10, 8'd200, 8'd90, 8'd128), 1'b0);
    send_pixel(px_of(8'd37, 8'd29, 8'd23, 8'd0), 1'b0);     // index hit
    send_pixel(px_of(8'd255, 8'd255, 8'd255, 8'd255), 1'b0);
    send_pixel(px_of(8'd255, 8'd255, 8'd255, 8'd255), 1'b0);
    send_pixel(px_of(8'd255, 8'd255, 8'd255, 8'd255), 1'b0);
    send_pixel(px_of(8'd255, 8'd255, 8'd255, 8'd255), 1'b1);
    send_pixel(px_of(8'd0, 8'd0, 8'd0, 8'd255), 1'b1);      // run of one, then marker
    send_pixel(px_of(8'd0, 8'd0, 8'd0, 8'd255), 1'b0);
    send_pixel(px_of(8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
    wait_drained();
    write_alpha(1'b0);
    send_pixel(px_of(8'd128, 8'd64, 8'd32, 8'd0), 1'b0);
    send_pixel(px_of(8'd128, 8'd64, 8'd32, 8'd7), 1'b0);
    send_pixel(px_of(8'd129, 8'd65, 8'd33, 8'd200), 1'b1);
    send_pixel(px_of(8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          tx_gap_max = 0;
          rx_gap_max = 0;
          write_alpha(1'b1);
        end
        1: begin
          tx_gap_max = 12;
          rx_gap_max = 12;
          write_alpha(1'b0);
        end
        2: begin
          tx_gap_max = 0;
          rx_gap_max = 3;
          rx_hold_req = 400;
          write_alpha(1'b1);
        end
        3: begin
          tx_gap_max = 12;
          rx_gap_max = 0;
          write_alpha(1'($urandom));
        end
        default: begin
          tx_gap_max = $urandom_range(12, 0);
          rx_gap_max = $urandom_range(12, 0);
          write_alpha(1'b1);
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (one_in(6)) begin
          reps = one_in(6) ? $urandom_range(130, 55) : $urandom_range(6, 1);
          if (reps > PHASE_ITEMS - sent) reps = PHASE_ITEMS - sent;
          repeat (reps) begin
            send_pixel(last_sent, one_in(60));
            sent++;
          end
        end else begin
          send_pixel(next_pixel(), one_in(40));
          sent++;
        end
      end
      wait_drained();
    end

    if (tracker.errors == 0 && tracker.pending_bytes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
